>>> rtl/core/twls_pkg.sv
// Shared types and constants for the text word and letter statistics block.
package twls_pkg;

  localparam int CHAR_W          = 8;
  localparam int LETTERS         = 26;
  localparam int IDX_W           = 5;
  localparam int OUT_W           = 32;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [CHAR_W-1:0] CH_TAB      = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF       = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE    = 8'd32;
  localparam logic [CHAR_W-1:0] CH_AMP      = 8'd38;
  localparam logic [CHAR_W-1:0] CH_COMMA    = 8'd44;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'd33;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'd125;
  localparam logic [CHAR_W-1:0] CH_UPPER_A  = 8'd65;
  localparam logic [CHAR_W-1:0] CH_UPPER_Z  = 8'd90;
  localparam logic [CHAR_W-1:0] CH_LOWER_A  = 8'd97;
  localparam logic [CHAR_W-1:0] CH_LOWER_Z  = 8'd122;

  localparam logic [IDX_W-1:0] LAST_LETTER = IDX_W'(LETTERS - 1);

  typedef enum logic {
    CMD_TEXT   = 1'b0,
    CMD_FINISH = 1'b1
  } cmd_t;

  // classified word passed from front to back
  typedef struct packed {
    cmd_t             cmd;
    logic             letter;
    logic             other;
    logic             sep;
    logic [IDX_W-1:0] idx;
  } class_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_SCAN,
    ST_EMIT
  } back_state_t;

endpackage

>>> rtl/core/twls_if.sv
// Channel interfaces: text input and statistics report output.
interface twls_in_if;
  logic                             valid;
  logic                             ready;
  logic                             command;
  logic [twls_pkg::CHAR_W-1:0]      char_code;

  modport source (output valid, command, char_code, input ready);
  modport sink   (input valid, command, char_code, output ready);
endinterface

interface twls_out_if;
  logic                             valid;
  logic                             ready;
  logic [twls_pkg::IDX_W-1:0]       letter_index;
  logic [twls_pkg::OUT_W-1:0]       letter_count;
  logic [twls_pkg::OUT_W-1:0]       letter_total;
  logic [twls_pkg::OUT_W-1:0]       word_count;
  logic [twls_pkg::OUT_W-1:0]       longest_len;
  logic [twls_pkg::OUT_W-1:0]       longest_index;
  logic [twls_pkg::IDX_W-1:0]       most_letter;
  logic [twls_pkg::IDX_W-1:0]       least_letter;
  logic                             last;

  modport source (output valid, letter_index, letter_count, letter_total, word_count,
                  longest_len, longest_index, most_letter, least_letter, last,
                  input ready);
  modport sink   (input valid, letter_index, letter_count, letter_total, word_count,
                  longest_len, longest_index, most_letter, least_letter, last,
                  output ready);
endinterface

>>> rtl/core/twls_front.sv
// Front end: accepts text words and classifies each byte.
module twls_front (
  twls_in_if.sink            text_in,
  output logic               push_valid,
  input  logic               push_ready,
  output twls_pkg::class_t   push_data
);

  logic [twls_pkg::CHAR_W-1:0] c;
  logic is_upper, is_lower, is_letter, is_sep, is_print;

  assign c = text_in.char_code;

  assign is_upper  = (c >= twls_pkg::CH_UPPER_A) && (c <= twls_pkg::CH_UPPER_Z);
  assign is_lower  = (c >= twls_pkg::CH_LOWER_A) && (c <= twls_pkg::CH_LOWER_Z);
  assign is_letter = is_upper || is_lower;
  assign is_sep    = (c == twls_pkg::CH_AMP) || (c == twls_pkg::CH_SPACE) ||
                     (c == twls_pkg::CH_TAB) || (c == twls_pkg::CH_LF) ||
                     (c == twls_pkg::CH_COMMA);
  assign is_print  = (c >= twls_pkg::CH_PRINT_LO) && (c <= twls_pkg::CH_PRINT_HI);

  always_comb begin
    push_data.cmd    = twls_pkg::cmd_t'(text_in.command);
    push_data.letter = is_letter;
    push_data.other  = is_print && !is_letter && !is_sep;
    push_data.sep    = is_sep;
    // 'A' and 'a' both have low bits 1, so low five bits minus one is the letter
    push_data.idx    = is_letter ? (c[twls_pkg::IDX_W-1:0] - twls_pkg::IDX_W'(1))
                                 : '0;
  end

  assign push_valid    = text_in.valid;
  assign text_in.ready = push_ready;

endmodule

>>> rtl/core/twls_queue.sv
// Short FIFO decoupling the classifier from the statistics engine.
module twls_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  twls_pkg::class_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output twls_pkg::class_t pop_data
);

  localparam int DEPTH = twls_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  twls_pkg::class_t  mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/core/twls_back.sv
// Back end: word and letter counters, histogram, report scan and emit.
module twls_back #(
  parameter int COUNT_WIDTH = twls_pkg::COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  twls_pkg::class_t pop_data,
  twls_out_if.source       stats_out
);

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  localparam int IW = twls_pkg::IDX_W;

  function automatic cnt_t sat_inc(cnt_t v);
    sat_inc = (&v) ? v : v + COUNT_WIDTH'(1);
  endfunction

  twls_pkg::back_state_t state, state_next;

  cnt_t          hist [twls_pkg::LETTERS];
  logic [IW-1:0] ptr;
  logic          skip;
  cnt_t          word_len, longest_len, longest_at, words, letters;
  cnt_t          max_val, min_val;
  logic [IW-1:0] most, least;

  logic          skip_next;
  cnt_t          word_len_next, longest_len_next, longest_at_next, words_next;
  cnt_t          words_inc;

  logic [IW-1:0] rd_addr;
  cnt_t          rd_data;
  logic          out_free, load_out, clear_all, text_op, ptr_end;

  assign out_free = !stats_out.valid || stats_out.ready;
  assign ptr_end  = (ptr == twls_pkg::LAST_LETTER);
  assign rd_data  = hist[rd_addr];

  always_comb begin
    state_next = state;
    unique case (state)
      twls_pkg::ST_RUN: begin
        if (pop_valid && pop_data.cmd == twls_pkg::CMD_FINISH) state_next = twls_pkg::ST_SCAN;
      end
      twls_pkg::ST_SCAN: begin
        if (ptr_end) state_next = twls_pkg::ST_EMIT;
      end
      twls_pkg::ST_EMIT: begin
        if (out_free && ptr_end) state_next = twls_pkg::ST_RUN;
      end
      default: state_next = twls_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    pop_ready = 1'b0;
    load_out  = 1'b0;
    clear_all = 1'b0;
    rd_addr   = ptr;
    unique case (state)
      twls_pkg::ST_RUN: begin
        pop_ready = 1'b1;
        rd_addr   = pop_data.idx;
      end
      twls_pkg::ST_SCAN: ;
      twls_pkg::ST_EMIT: begin
        load_out  = out_free;
        clear_all = out_free && ptr_end;
      end
      default: ;
    endcase
  end

  assign text_op = pop_valid && pop_ready && (pop_data.cmd == twls_pkg::CMD_TEXT);

  // word tracking
  always_comb begin
    skip_next        = skip;
    word_len_next    = word_len;
    longest_len_next = longest_len;
    longest_at_next  = longest_at;
    words_inc        = sat_inc(words);
    words_next       = words;
    if (pop_data.letter || pop_data.other) begin
      // a word opening on punctuation is dropped
      if (word_len == '0 && pop_data.other) skip_next = 1'b1;
      if (!skip_next) word_len_next = sat_inc(word_len);
    end
    if (pop_data.sep) begin
      skip_next = 1'b0;
      if (word_len != '0) begin
        words_next    = words_inc;
        word_len_next = '0;
        if (word_len > longest_len) begin
          longest_len_next = word_len;
          longest_at_next  = words_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= twls_pkg::ST_RUN;
      ptr         <= '0;
      skip        <= 1'b0;
      word_len    <= '0;
      longest_len <= '0;
      longest_at  <= '0;
      words       <= '0;
      letters     <= '0;
      for (int i = 0; i < twls_pkg::LETTERS; i++) hist[i] <= '0;
      stats_out.valid <= 1'b0;
    end else begin
      state <= state_next;

      if (load_out) begin
        stats_out.valid <= 1'b1;
      end else if (stats_out.ready) begin
        stats_out.valid <= 1'b0;
      end

      if (state == twls_pkg::ST_RUN) begin
        ptr <= '0;
      end else if (state == twls_pkg::ST_SCAN) begin
        ptr <= ptr_end ? '0 : ptr + IW'(1);
      end else if (load_out) begin
        ptr <= ptr_end ? '0 : ptr + IW'(1);
      end

      if (clear_all) begin
        skip        <= 1'b0;
        word_len    <= '0;
        longest_len <= '0;
        longest_at  <= '0;
        words       <= '0;
        letters     <= '0;
        for (int i = 0; i < twls_pkg::LETTERS; i++) hist[i] <= '0;
      end else if (text_op) begin
        skip        <= skip_next;
        word_len    <= word_len_next;
        longest_len <= longest_len_next;
        longest_at  <= longest_at_next;
        words       <= words_next;
        if (pop_data.letter) begin
          hist[pop_data.idx] <= sat_inc(rd_data);
          letters            <= sat_inc(letters);
        end
      end
    end
  end

  // running max/min over the histogram, strict compare keeps the lowest index
  always_ff @(posedge clk) begin
    if (state == twls_pkg::ST_SCAN) begin
      if (ptr == '0) begin
        most    <= '0;
        least   <= '0;
        max_val <= rd_data;
        min_val <= rd_data;
      end else begin
        if (rd_data > max_val) begin
          most    <= ptr;
          max_val <= rd_data;
        end
        if (rd_data < min_val) begin
          least   <= ptr;
          min_val <= rd_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      stats_out.letter_index  <= ptr;
      stats_out.letter_count  <= twls_pkg::OUT_W'(rd_data);
      stats_out.letter_total  <= twls_pkg::OUT_W'(letters);
      stats_out.word_count    <= twls_pkg::OUT_W'(words);
      stats_out.longest_len   <= twls_pkg::OUT_W'(longest_len);
      stats_out.longest_index <= twls_pkg::OUT_W'(longest_at);
      stats_out.most_letter   <= most;
      stats_out.least_letter  <= least;
      stats_out.last          <= ptr_end;
    end
  end

endmodule

>>> rtl/core/text_word_letter_stats.sv
// Top level: text word and letter statistics with decoupled classifier and counters.
//
//   channel    modport  handshake     payload
//   text_in    sink     valid/ready   command, char_code
//   stats_out  source   valid/ready   letter_index .. last, 26 words per report
//
// Text words are taken one per cycle while the counters run; a two-entry queue sits
// between the classifier and the counter engine. A finish word starts a histogram
// scan for the most/least letters, then 26 report words at one per cycle while
// stats_out does not stall; the queue keeps accepting text until it fills.
// rst clears all counters and the histogram at once; no clearing pass is needed.
module text_word_letter_stats #(
  parameter int COUNT_WIDTH = twls_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  twls_in_if.sink     text_in,
  twls_out_if.source  stats_out
);

  logic             push_valid, push_ready;
  logic             pop_valid, pop_ready;
  twls_pkg::class_t push_data, pop_data;

  twls_front u_front (
    .text_in    (text_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  twls_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  twls_back #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .stats_out (stats_out)
  );

endmodule
